@@ hdl/lsra_pkg.sv @@
// Shared types and constants for the linear scan register allocator.
// Holds the transfer payload structs and the compare unit result type.
// No dependencies.
package lsra_pkg;

	// Fixed field widths of the transfer payloads
	localparam int ID_W      = 16;
	localparam int KEY_W     = 16;
	localparam int FLD_POS_W = 16;
	localparam int OUT_REG_W = 4;
	localparam int STEP_W    = 16;
	localparam int CFG_W     = 5;

	// Defaults for the top level parameters
	localparam int DEF_MAX_PHYS_REGS = 16;
	localparam int DEF_POS_WIDTH     = 16;

	// One live interval
	typedef struct packed {
		logic                 start_list;
		logic [ID_W-1:0]      interval_id;
		logic [FLD_POS_W-1:0] interval_start;
		logic [FLD_POS_W-1:0] interval_end;
		logic [KEY_W-1:0]     tie_key;
	} in_item_t;

	// One allocation result
	typedef struct packed {
		logic                 assigned_valid;
		logic [OUT_REG_W-1:0] assigned_reg;
		logic                 spill_happened;
		logic [ID_W-1:0]      spilled_id;
		logic [STEP_W-1:0]    step_index;
	} out_item_t;

	// Compare unit flags
	typedef struct packed {
		logic expired;
		logic take;
	} cmp_res_t;

endpackage

@@ hdl/lsra_cmp.sv @@
// Shared compare unit: expiry test and spill ordering of one active slot.
// Depends on lsra_pkg.
module lsra_cmp #(
	parameter int POS_W = lsra_pkg::DEF_POS_WIDTH
) (
	input  logic [POS_W-1:0]          cur_start,
	input  logic [POS_W-1:0]          slot_start,
	input  logic [POS_W-1:0]          slot_stop,
	input  logic [lsra_pkg::KEY_W-1:0] slot_key,
	input  logic [POS_W-1:0]          best_start,
	input  logic [POS_W-1:0]          best_stop,
	input  logic [lsra_pkg::KEY_W-1:0] best_key,
	output lsra_pkg::cmp_res_t        res
);
	import lsra_pkg::*;

	// slot expires when its end is at or before the new start;
	// spill order: later end, then smaller key, then smaller or equal start
	always_comb begin
		res.expired = (cur_start >= slot_stop);
		if (slot_stop != best_stop) begin
			res.take = (slot_stop > best_stop);
		end else if (slot_key != best_key) begin
			res.take = (slot_key < best_key);
		end else begin
			res.take = (slot_start <= best_start);
		end
	end

endmodule

@@ hdl/lsra_slots.sv @@
// Active interval storage: flop array with one read and one write port.
// Entries above the fill count are never read. Depends on lsra_pkg.
module lsra_slots #(
	parameter int DEPTH = lsra_pkg::DEF_MAX_PHYS_REGS,
	parameter int IDX_W = 4,
	parameter int ENT_W = 68
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] widx,
	input  logic [ENT_W-1:0] wdata,
	input  logic [IDX_W-1:0] ridx,
	output logic [ENT_W-1:0] rdata
);
	import lsra_pkg::*;

	logic [ENT_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[widx] <= wdata;
		end
	end

	// read port
	assign rdata = mem_q[ridx];

endmodule

@@ hdl/linear_scan_register_allocator_unit.sv @@
// Linear scan register allocator, one live interval per transfer.
// The expiry walk covers the intervals active before the item (at most 16 at 16
// registers); one item in flight, so the next input transfer waits until the
// result is loaded into the output register, which out_stall can hold off.
// The expiry walk reads one slot a cycle through the shared compare unit.
// Reset (arst_n low): empty active list, all registers free, step 0, 16 registers.
module linear_scan_register_allocator_unit #(
	parameter int MAX_PHYS_REGS = lsra_pkg::DEF_MAX_PHYS_REGS,
	parameter int POS_WIDTH     = lsra_pkg::DEF_POS_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  lsra_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output lsra_pkg::out_item_t        out_data,
	input  logic                       cfg_we,
	input  logic [lsra_pkg::CFG_W-1:0] cfg_wdata
);
	import lsra_pkg::*;

	localparam int IDX_W = (MAX_PHYS_REGS > 1) ? $clog2(MAX_PHYS_REGS) : 1;
	localparam int CNT_W = $clog2(MAX_PHYS_REGS + 1);

	typedef struct packed {
		logic [ID_W-1:0]      id;
		logic [POS_WIDTH-1:0] start;
		logic [POS_WIDTH-1:0] stop;
		logic [KEY_W-1:0]     key;
		logic [IDX_W-1:0]     phys;
	} slot_t;

	localparam int ENT_W = $bits(slot_t);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXP    = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_SHIFT  = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]             state_q;
	logic [CFG_W-1:0]       nregs_q;
	slot_t                  cur_q;
	slot_t                  best_q;
	logic                   has_pick_q;
	logic [CNT_W-1:0]       pick_q;
	logic [CNT_W-1:0]       rd_q;
	logic [CNT_W-1:0]       wr_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [MAX_PHYS_REGS-1:0] free_q;
	logic [STEP_W-1:0]      step_q;
	logic                   res_valid_q;
	logic [IDX_W-1:0]       res_reg_q;
	logic                   res_spill_q;
	logic [ID_W-1:0]        res_sid_q;
	logic                   out_valid_q;
	out_item_t              out_q;

	logic                   in_xfer;
	logic                   out_load;
	logic                   rd_end;
	logic [CNT_W-1:0]       k_eff;
	logic                   lt_k;
	logic                   free_found;
	logic [IDX_W-1:0]       free_idx;
	logic [ENT_W-1:0]       rd_bits;
	slot_t                  slot_rd;
	cmp_res_t               cmp;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_idx;
	slot_t                  wr_ent;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign rd_end    = (rd_q == cnt_q);
	assign slot_rd   = slot_t'(rd_bits);

	// effective register count, capped at the physical maximum
	always_comb begin
		if (int'(nregs_q) > MAX_PHYS_REGS) begin
			k_eff = CNT_W'(MAX_PHYS_REGS);
		end else begin
			k_eff = CNT_W'(nregs_q);
		end
	end
	assign lt_k = (cnt_q < k_eff);

	// lowest free register below the effective count
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int r = MAX_PHYS_REGS - 1; r >= 0; r--) begin
			if (free_q[r] && (r < int'(k_eff))) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(r);
			end
		end
	end

	// slot store
	lsra_slots #(
		.DEPTH (MAX_PHYS_REGS),
		.IDX_W (IDX_W),
		.ENT_W (ENT_W)
	) u_slots (
		.clk   (clk),
		.we    (wr_en),
		.widx  (wr_idx),
		.wdata (ENT_W'(wr_ent)),
		.ridx  (rd_q[IDX_W-1:0]),
		.rdata (rd_bits)
	);

	// shared compare unit
	lsra_cmp #(
		.POS_W (POS_WIDTH)
	) u_cmp (
		.cur_start  (cur_q.start),
		.slot_start (slot_rd.start),
		.slot_stop  (slot_rd.stop),
		.slot_key   (slot_rd.key),
		.best_start (best_q.start),
		.best_stop  (best_q.stop),
		.best_key   (best_q.key),
		.res        (cmp)
	);

	// slot write port: compaction, append, victim removal
	always_comb begin
		wr_en  = 1'b0;
		wr_idx = wr_q[IDX_W-1:0];
		wr_ent = slot_rd;
		case (state_q)
			ST_EXP: begin
				wr_en = !rd_end && !cmp.expired;
			end
			ST_DECIDE: begin
				wr_en       = lt_k && free_found;
				wr_idx      = cnt_q[IDX_W-1:0];
				wr_ent      = cur_q;
				wr_ent.phys = free_idx;
			end
			ST_SHIFT: begin
				wr_en = 1'b1;
				if (rd_end) begin
					wr_ent      = cur_q;
					wr_ent.phys = best_q.phys;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nregs_q <= CFG_W'(16);
		end else if (cfg_we) begin
			nregs_q <= cfg_wdata;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			free_q     <= '1;
			step_q     <= '0;
			rd_q       <= '0;
			wr_q       <= '0;
			has_pick_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (in_data.start_list) begin
							cnt_q  <= '0;
							free_q <= '1;
							step_q <= '0;
						end
						rd_q       <= '0;
						wr_q       <= '0;
						has_pick_q <= 1'b0;
						state_q    <= ST_EXP;
					end
				end
				ST_EXP: begin
					if (rd_end) begin
						cnt_q   <= wr_q;
						state_q <= ST_DECIDE;
					end else begin
						rd_q <= rd_q + CNT_W'(1);
						if (cmp.expired) begin
							free_q[slot_rd.phys] <= 1'b1;
						end else begin
							wr_q <= wr_q + CNT_W'(1);
							if (cmp.take) begin
								has_pick_q <= 1'b1;
							end
						end
					end
				end
				ST_DECIDE: begin
					if (lt_k) begin
						if (free_found) begin
							free_q[free_idx] <= 1'b0;
							cnt_q            <= cnt_q + CNT_W'(1);
						end
						state_q <= ST_DONE;
					end else if (!has_pick_q) begin
						state_q <= ST_DONE;
					end else begin
						rd_q    <= pick_q + CNT_W'(1);
						wr_q    <= pick_q;
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (rd_end) begin
						free_q[best_q.phys] <= 1'b0;
						state_q             <= ST_DONE;
					end else begin
						rd_q <= rd_q + CNT_W'(1);
						wr_q <= wr_q + CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (out_load) begin
						step_q  <= step_q + STEP_W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item, spill candidate and result registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cur_q.id    <= in_data.interval_id;
			cur_q.start <= POS_WIDTH'(in_data.interval_start);
			cur_q.stop  <= POS_WIDTH'(in_data.interval_end);
			cur_q.key   <= in_data.tie_key;
			cur_q.phys  <= '0;
			best_q.id    <= in_data.interval_id;
			best_q.start <= POS_WIDTH'(in_data.interval_start);
			best_q.stop  <= POS_WIDTH'(in_data.interval_end);
			best_q.key   <= in_data.tie_key;
			best_q.phys  <= '0;
		end
		if ((state_q == ST_EXP) && !rd_end && !cmp.expired && cmp.take) begin
			best_q <= slot_rd;
			pick_q <= wr_q;
		end
		if (state_q == ST_DECIDE) begin
			res_spill_q <= !lt_k;
			if (lt_k) begin
				res_sid_q   <= '0;
				res_valid_q <= free_found;
				res_reg_q   <= free_idx;
			end else if (!has_pick_q) begin
				res_sid_q   <= cur_q.id;
				res_valid_q <= 1'b0;
				res_reg_q   <= '0;
			end else begin
				res_sid_q   <= best_q.id;
				res_valid_q <= 1'b1;
				res_reg_q   <= best_q.phys;
			end
		end
		if (out_load) begin
			out_q.assigned_valid <= res_valid_q;
			out_q.assigned_reg   <= res_valid_q ? OUT_REG_W'(res_reg_q) : '0;
			out_q.spill_happened <= res_spill_q;
			out_q.spilled_id     <= res_sid_q;
			out_q.step_index     <= step_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_PHYS_REGS))
		else $error("active count above register maximum");

	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && lt_k && free_found) |=> !free_q[$past(free_idx)])
		else $error("allocated register still marked free");

	a_shift_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (rd_q == wr_q + CNT_W'(1)))
		else $error("victim removal pointers out of step");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result presented outside completion");
`endif

endmodule

@@ dv/linear_scan_register_allocator_unit_test.sv @@
`timescale 1ns / 100ps
// Testbench for linear_scan_register_allocator_unit: directed intervals, then random lists.
// Predicts each allocation result in SystemVerilog, or takes it from the directed table, and checks it field by field.
// Depends on lsra_pkg and the allocator RTL.
module linear_scan_register_allocator_unit_test;
	import lsra_pkg::*;

	localparam int SLOTS          = DEF_MAX_PHYS_REGS;
	localparam int RAND_ITEMS     = 850;
	localparam int TAIL_ITEMS     = 100;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 90;
	localparam int DRAIN_CYCLES   = 40;
	localparam int STALL_LIMIT    = 3000;
	localparam logic [CFG_W-1:0] REGS_NONE = 5'd0;
	localparam logic [CFG_W-1:0] REGS_ONE  = 5'd1;
	localparam logic [CFG_W-1:0] REGS_FULL = 5'd16;
	localparam logic [CFG_W-1:0] REGS_OVER = 5'd31;

	// One directed row: optional register write, the interval, optional typed result
	typedef struct packed {
		logic                 set_cfg;
		logic [CFG_W-1:0]     cfg_val;
		logic                 sl;
		logic [ID_W-1:0]      id;
		logic [FLD_POS_W-1:0] st;
		logic [FLD_POS_W-1:0] en;
		logic [KEY_W-1:0]     key;
		logic                 chk;
		logic                 av;
		logic [OUT_REG_W-1:0] ar;
		logic                 sh;
		logic [ID_W-1:0]      sid;
		logic [STEP_W-1:0]    stp;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_item_t         in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_data;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// Typed expectation travels with the interval it belongs to
	logic      use_typed = 1'b0;
	out_item_t typed_result = '0;

	// Allocator state as predicted
	logic [CFG_W-1:0]     reg_limit = REGS_FULL;
	int                   n_act = 0;
	logic [ID_W-1:0]      act_id    [SLOTS];
	logic [FLD_POS_W-1:0] act_start [SLOTS];
	logic [FLD_POS_W-1:0] act_end   [SLOTS];
	logic [KEY_W-1:0]     act_key   [SLOTS];
	logic [OUT_REG_W-1:0] act_phys  [SLOTS];
	logic [SLOTS-1:0]     reg_free = '1;
	logic [STEP_W-1:0]    step_cnt = '0;

	out_item_t pending_alloc[$];
	dir_row_t  dir_tab[$];
	int        n_sent = 0;
	int        n_done = 0;
	int        mismatches = 0;
	int        idle_cycles = 0;
	bit        hold_req = 1'b0;
	bit        rx_gaps = 1'b0;

	linear_scan_register_allocator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// Append one row to the directed table
	function automatic void add_row(dir_row_t row);
		dir_tab.insert(dir_tab.size(), row);
	endfunction

	// Remove one active interval, keeping the rest in insertion order
	function automatic void drop_slot(int idx);
		for (int i = idx; i + 1 < n_act; i++) begin
			act_id[i]    = act_id[i + 1];
			act_start[i] = act_start[i + 1];
			act_end[i]   = act_end[i + 1];
			act_key[i]   = act_key[i + 1];
			act_phys[i]  = act_phys[i + 1];
		end
		n_act--;
	endfunction

	// Expire, allocate or spill for one interval; updates the predicted state
	function automatic out_item_t allocate_interval(in_item_t it);
		out_item_t            res;
		int                   lim;
		int                   pick;
		int                   i;
		bit                   got_reg;
		bit                   spilled;
		bit                   take;
		logic [OUT_REG_W-1:0] preg;
		logic [ID_W-1:0]      victim;
		logic [FLD_POS_W-1:0] ce;
		logic [FLD_POS_W-1:0] cs;
		logic [KEY_W-1:0]     ck;
		res = '0;
		got_reg = 1'b0;
		spilled = 1'b0;
		preg = '0;
		victim = '0;
		if (it.start_list) begin
			n_act = 0;
			reg_free = '1;
			step_cnt = '0;
		end
		lim = (reg_limit > SLOTS) ? SLOTS : int'(reg_limit);
		// free registers of intervals ending at or before the new start
		i = 0;
		while (i < n_act) begin
			if (it.interval_start >= act_end[i]) begin
				reg_free[act_phys[i]] = 1'b1;
				drop_slot(i);
			end else begin
				i++;
			end
		end
		if (n_act < lim) begin
			for (int r = 0; r < lim; r++) begin
				if (reg_free[r] && !got_reg) begin
					preg = OUT_REG_W'(r);
					got_reg = 1'b1;
				end
			end
		end else begin
			// newcomer is the first candidate, then the active list in order
			pick = -1;
			ce = it.interval_end;
			ck = it.tie_key;
			cs = it.interval_start;
			for (i = 0; i < n_act; i++) begin
				if (act_end[i] != ce)
					take = act_end[i] > ce;
				else if (act_key[i] != ck)
					take = act_key[i] < ck;
				else
					take = act_start[i] <= cs;
				if (take) begin
					pick = i;
					ce = act_end[i];
					ck = act_key[i];
					cs = act_start[i];
				end
			end
			spilled = 1'b1;
			if (pick < 0) begin
				victim = it.interval_id;
			end else begin
				victim = act_id[pick];
				preg = act_phys[pick];
				got_reg = 1'b1;
				drop_slot(pick);
			end
		end
		if (got_reg && n_act < SLOTS) begin
			reg_free[preg] = 1'b0;
			act_id[n_act] = it.interval_id;
			act_start[n_act] = it.interval_start;
			act_end[n_act] = it.interval_end;
			act_key[n_act] = it.tie_key;
			act_phys[n_act] = preg;
			n_act++;
		end
		res.assigned_valid = got_reg;
		res.assigned_reg = got_reg ? preg : '0;
		res.spill_happened = spilled;
		res.spilled_id = victim;
		res.step_index = step_cnt;
		step_cnt++;
		return res;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Monitor: predict on each input transfer, check each output transfer
	always @(posedge clk) begin
		out_item_t want;
		out_item_t pred;
		if (arst_n) begin
			if (cfg_we)
				reg_limit = cfg_wdata;
			if (in_valid && !in_stall) begin
				pred = allocate_interval(in_data);
				pending_alloc.insert(pending_alloc.size(), use_typed ? typed_result : pred);
			end
			if (out_valid && !out_stall) begin
				n_done++;
				if (pending_alloc.size() == 0) begin
					$display("%0t: result with none expected, expected none, actual %h",
						$time, out_data);
					mismatches++;
				end else begin
					want = pending_alloc.pop_front();
					check_field("assigned_valid", want.assigned_valid, out_data.assigned_valid);
					check_field("assigned_reg", want.assigned_reg, out_data.assigned_reg);
					check_field("spill_happened", want.spill_happened, out_data.spill_happened);
					check_field("spilled_id", want.spilled_id, out_data.spilled_id);
					check_field("step_index", want.step_index, out_data.step_index);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result side: random stall bursts, plus one long hold on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one interval and hold it until the transfer; valid stays high afterwards
	task automatic offer(input in_item_t it, input logic chk, input out_item_t want);
		in_valid <= 1'b1;
		in_data <= it;
		use_typed <= chk;
		typed_result <= want;
		do @(posedge clk); while (in_stall);
		n_sent++;
	endtask

	task automatic wait_drained();
		while (n_done != n_sent) @(posedge clk);
	endtask

	// Register write only with the block idle
	task automatic write_limit(input logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		in_item_t         item;
		out_item_t        want;
		logic [CFG_W-1:0] cfg_val;
		int               ph;
		int               len;
		int               pos;
		int               stop;
		int               tx_odds;
		bit               keep;
		bit               tail;

		// set_cfg, cfg, start_list, id, start, end, key, typed, valid, reg, spill, spill id, step
		// first use, an empty interval, reuse after expiry
		add_row('{1'b0, REGS_NONE, 1'b1, 16'h0001, 16'h0000, 16'hFFFF, 16'h0000,
			1'b1, 1'b1, 4'd0, 1'b0, 16'h0000, 16'd0});
		add_row('{1'b0, REGS_NONE, 1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
			1'b1, 1'b1, 4'd1, 1'b0, 16'h0000, 16'd1});
		add_row('{1'b0, REGS_NONE, 1'b0, 16'h0003, 16'h0001, 16'h0005, 16'h0003,
			1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0});
		// register count lowered with two intervals live
		add_row('{1'b1, REGS_ONE, 1'b0, 16'h0004, 16'h0002, 16'h000A, 16'h0000,
			1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0});
		add_row('{1'b0, REGS_NONE, 1'b0, 16'h0005, 16'h0006, 16'h0008, 16'h0000,
			1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0});
		// full tie goes against the active interval, then key and end decide
		add_row('{1'b0, REGS_NONE, 1'b1, 16'h0010, 16'h0020, 16'h0064, 16'h0005,
			1'b1, 1'b1, 4'd0, 1'b0, 16'h0000, 16'd0});
		add_row('{1'b0, REGS_NONE, 1'b0, 16'h0011, 16'h0020, 16'h0064, 16'h0005,
			1'b1, 1'b1, 4'd0, 1'b1, 16'h0010, 16'd1});
		add_row('{1'b0, REGS_NONE, 1'b0, 16'h0012, 16'h0021, 16'h0064, 16'h0004,
			1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0});
		add_row('{1'b0, REGS_NONE, 1'b0, 16'h0013, 16'h0022, 16'h0064, 16'h0009,
			1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0});
		add_row('{1'b0, REGS_NONE, 1'b0, 16'h0014, 16'h0023, 16'h0080, 16'h0000,
			1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0});
		// no registers: each newcomer spills itself
		add_row('{1'b1, REGS_NONE, 1'b1, 16'hABCD, 16'h1234, 16'h5678, 16'h0000,
			1'b1, 1'b0, 4'd0, 1'b1, 16'hABCD, 16'd0});
		add_row('{1'b0, REGS_NONE, 1'b0, 16'h5432, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b1, 1'b0, 4'd0, 1'b1, 16'h5432, 16'd1});
		// count above the slot total acts as the full set
		add_row('{1'b1, REGS_OVER, 1'b1, 16'h0100, 16'h0000, 16'h0010, 16'h0000,
			1'b1, 1'b1, 4'd0, 1'b0, 16'h0000, 16'd0});
		add_row('{1'b0, REGS_NONE, 1'b0, 16'h0101, 16'h0000, 16'h0010, 16'h0000,
			1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0});
		add_row('{1'b0, REGS_NONE, 1'b0, 16'h0102, 16'hFFFF, 16'hFFFF, 16'h8000,
			1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 16'd0});
		add_row('{1'b1, REGS_FULL, 1'b1, 16'h7FFF, 16'h8000, 16'h8001, 16'h7FFF,
			1'b1, 1'b1, 4'd0, 1'b0, 16'h0000, 16'd0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (dir_tab[r]) begin
			if (dir_tab[r].set_cfg)
				write_limit(dir_tab[r].cfg_val);
			item.start_list = dir_tab[r].sl;
			item.interval_id = dir_tab[r].id;
			item.interval_start = dir_tab[r].st;
			item.interval_end = dir_tab[r].en;
			item.tie_key = dir_tab[r].key;
			want.assigned_valid = dir_tab[r].av;
			want.assigned_reg = dir_tab[r].ar;
			want.spill_happened = dir_tab[r].sh;
			want.spilled_id = dir_tab[r].sid;
			want.step_index = dir_tab[r].stp;
			offer(item, dir_tab[r].chk, want);
		end

		// Random lists; each phase write drains the block first, none in the last part
		want = '0;
		stop = n_sent + RAND_ITEMS;
		ph = 0;
		while (n_sent < stop) begin
			case (ph % 6)
				0: cfg_val = REGS_FULL;
				1: cfg_val = REGS_ONE;
				2: cfg_val = REGS_NONE;
				3: cfg_val = REGS_OVER;
				4: cfg_val = CFG_W'($urandom_range(2, 15));
				default: cfg_val = CFG_W'($urandom_range(0, 31));
			endcase
			tail = n_sent >= stop - TAIL_ITEMS;
			if (!tail)
				write_limit(cfg_val);
			tx_odds = tail ? 0 : $urandom_range(0, 3);
			rx_gaps = !tail && $urandom_range(0, 3) != 0;
			// long result hold while intervals keep coming
			if (ph == 3)
				hold_req = 1'b1;
			// now and then carry the live list across the register change
			keep = $urandom_range(0, 7) == 0;
			pos = ($urandom_range(0, 9) == 0) ? $urandom_range(60000, 65535)
				: $urandom_range(0, 64);
			len = $urandom_range(8, 40);
			for (int j = 0; j < len; j++) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: any field value, out of start order
					item.start_list = $urandom_range(0, 7) == 0;
					item.interval_id = ID_W'($urandom);
					item.interval_start = FLD_POS_W'($urandom);
					item.interval_end = FLD_POS_W'($urandom);
					item.tie_key = KEY_W'($urandom);
				end else begin
					item.start_list = (j == 0) && !keep;
					item.interval_id = ID_W'($urandom);
					pos = pos + $urandom_range(0, 3);
					if (pos > 65535)
						pos = 65535;
					item.interval_start = FLD_POS_W'(pos);
					case ($urandom_range(0, 9))
						0: item.interval_end = FLD_POS_W'(pos - $urandom_range(0, 2));
						1: item.interval_end = '1;
						default: item.interval_end = FLD_POS_W'((pos + $urandom_range(1, 48) > 65535)
							? 65535 : pos + $urandom_range(1, 48));
					endcase
					// narrow keys make ties on equal ends common
					item.tie_key = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom)
						: KEY_W'($urandom_range(0, 3));
				end
				offer(item, 1'b0, want);
				if (tx_odds != 0 && $urandom_range(1, 6) <= tx_odds) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 13)) @(posedge clk);
				end
			end
			ph++;
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_alloc.size() != 0) begin
			$display("%0t: %0d results never arrived, expected %h, actual none",
				$time, pending_alloc.size(), pending_alloc[0]);
			mismatches++;
		end
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
